// ----- design/crwh_pkg.sv -----
// ---------------------------------------------------------------------------
// crwh_pkg
// Shared types, constants and the per-stage mixing function of the
// counter random word hash.
// ---------------------------------------------------------------------------
`default_nettype none

package crwh_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned S_DATA_W = 192;
  localparam int unsigned M_DATA_W = 56;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 64;

  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;
  localparam int unsigned       XSH     = 16;

  localparam int unsigned ROUND_STAGES = 7;

  // register select, taken from paddr[3]
  typedef enum logic {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_sel_t;

  typedef enum logic [2:0] {
    ST_LCG = 3'd0,
    ST_MX1 = 3'd1,
    ST_MY1 = 3'd2,
    ST_MZ1 = 3'd3,
    ST_MX2 = 3'd4,
    ST_MY2 = 3'd5,
    ST_MZ2 = 3'd6
  } stage_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] fold;
  } hash_t;

  function automatic logic [WORD_W-1:0] xsh(input logic [WORD_W-1:0] v);
    xsh = v ^ (v >> XSH);
  endfunction

  // One pipeline stage of a pcg3d round. The last stage folds the carried
  // word into x and clears it, so a second round sees no fold.
  function automatic hash_t mix_stage(input stage_t st, input hash_t h);
    hash_t r;
    r = h;
    case (st)
      ST_LCG: begin
        r.x = h.x * LCG_MUL + LCG_ADD;
        r.y = h.y * LCG_MUL + LCG_ADD;
        r.z = h.z * LCG_MUL + LCG_ADD;
      end
      ST_MX1, ST_MX2: r.x = h.x + h.y * h.z;
      ST_MY1, ST_MY2: r.y = h.y + h.z * h.x;
      ST_MZ1: begin
        r.z = h.z + h.x * h.y;
        r.x = xsh(h.x);
        r.y = xsh(h.y);
        r.z = xsh(r.z);
      end
      ST_MZ2: begin
        r.z    = h.z + h.x * h.y;
        r.x    = h.x ^ h.fold;
        r.fold = '0;
      end
      default: r = h;
    endcase
    mix_stage = r;
  endfunction

endpackage

`default_nettype wire

// ----- design/crwh_keys.sv -----
// ---------------------------------------------------------------------------
// crwh_keys
// APB register file holding the 128-bit generator key.
// ---------------------------------------------------------------------------
`default_nettype none

module crwh_keys (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crwh_pkg::APB_AW-1:0]   paddr,
  input  wire logic [crwh_pkg::APB_DW-1:0]   pwdata,
  output logic      [crwh_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output logic      [crwh_pkg::KEY_W-1:0]    key_low,
  output logic      [crwh_pkg::KEY_W-1:0]    key_high
);
  import crwh_pkg::*;

  reg_sel_t sel;
  logic     wr;

  assign sel    = reg_sel_t'(paddr[3]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_KEY_HIGH: key_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_KEY_LOW:  prdata = key_low;
      REG_KEY_HIGH: prdata = key_high;
      default:      prdata = '0;
    endcase
  end

  // low address bits are not decoded
  logic unused_addr;
  assign unused_addr = ^paddr[2:0];

endmodule

`default_nettype wire

// ----- design/crwh_round.sv -----
// ---------------------------------------------------------------------------
// crwh_round
// One pcg3d round as seven register stages, at most one multiply per lane each,
// with valid bits and a per-stage ready chain.
// ---------------------------------------------------------------------------
`default_nettype none

module crwh_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire crwh_pkg::hash_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output crwh_pkg::hash_t      out_data
);
  import crwh_pkg::*;

  logic  [ROUND_STAGES-1:0] v;
  logic  [ROUND_STAGES-1:0] v_in;
  logic  [ROUND_STAGES-1:0] rdy;
  hash_t                    d     [ROUND_STAGES];
  hash_t                    d_next[ROUND_STAGES];

  for (genvar i = 0; i < ROUND_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign d_next[i] = mix_stage(stage_t'(i), in_data);
      assign v_in[i]   = in_valid;
    end else begin : g_rest
      assign d_next[i] = mix_stage(stage_t'(i), d[i-1]);
      assign v_in[i]   = v[i-1];
    end

    if (i == ROUND_STAGES - 1) begin : g_last_rdy
      assign rdy[i] = !v[i] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[i] = !v[i] || rdy[i+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        d[i] <= d_next[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[ROUND_STAGES-1];
  assign out_data  = d[ROUND_STAGES-1];

endmodule

`default_nettype wire

// ----- design/counter_random_word_hash.sv -----
// ---------------------------------------------------------------------------
// counter_random_word_hash
// Keyed counter/lattice-cell random word generator on two pcg3d rounds.
// ---------------------------------------------------------------------------
// One request is taken every cycle while the output is not stalled; each
// result passes through the two pcg3d rounds, each cut into seven stages
// of at most one 32x32 multiply per lane. Items are independent, so stalls
// only hold the pipeline in place.
// Key registers: key_low at 0x0, key_high at 0x8; write them only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module counter_random_word_hash (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [crwh_pkg::APB_AW-1:0]    paddr,
  input  wire logic [crwh_pkg::APB_DW-1:0]    pwdata,
  output logic      [crwh_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  // requests
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [crwh_pkg::S_DATA_W-1:0]  s_tdata,  // counter, cell_x, cell_y, cell_z, lane
  input  wire logic                           s_tuser,  // kind
  // results
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [crwh_pkg::M_DATA_W-1:0]  m_tdata   // word, fraction
);
  import crwh_pkg::*;

  logic [KEY_W-1:0]  key_low;
  logic [KEY_W-1:0]  key_high;
  logic [CNT_W-1:0]  counter;
  logic [WORD_W-1:0] cell_x;
  logic [WORD_W-1:0] cell_y;
  logic [WORD_W-1:0] cell_z;
  logic [WORD_W-1:0] lane;
  logic              kind;
  hash_t             seed;
  hash_t             mid;
  hash_t             fin;
  logic              mid_valid;
  logic              mid_ready;

  crwh_keys u_keys (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .key_low  (key_low),
    .key_high (key_high)
  );

  assign counter = s_tdata[63:0];
  assign cell_x  = s_tdata[95:64];
  assign cell_y  = s_tdata[127:96];
  assign cell_z  = s_tdata[159:128];
  assign lane    = s_tdata[191:160];
  assign kind    = s_tuser;

  always_comb begin
    if (kind) begin
      seed.x    = cell_x ^ key_low[31:0];
      seed.y    = cell_y ^ key_low[63:32];
      seed.z    = cell_z ^ key_high[31:0];
      seed.fold = key_high[63:32] ^ lane;
    end else begin
      seed.x    = counter[31:0] ^ key_low[31:0];
      seed.y    = counter[63:32] ^ key_low[63:32];
      seed.z    = lane ^ key_high[31:0];
      seed.fold = key_high[63:32];
    end
  end

  crwh_round u_round1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (seed),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid)
  );

  crwh_round u_round2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (fin)
  );

  assign m_tdata = {fin.x[WORD_W-1:WORD_W-FRAC_W], fin.x};

  logic unused_fold;
  assign unused_fold = ^fin.y ^ ^fin.z ^ ^fin.fold;

endmodule

`default_nettype wire

// ----- design/crwh_checker.sv -----
// ---------------------------------------------------------------------------
// crwh_checker
// Port-level checks on the counter random word hash.
// ---------------------------------------------------------------------------
`default_nettype none

module crwh_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           pready,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [crwh_pkg::M_DATA_W-1:0]  m_tdata
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_frac: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:32] == m_tdata[31:8])
    else $error("fraction does not match word");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind counter_random_word_hash crwh_checker u_crwh_checker (
  .clk      (clk),
  .rst      (rst),
  .pready   (pready),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
